// File: sv/timeout_stack_manager_top_defines.svh
// Assertion macros for the timeout stack manager.
// Used by timeout_stack_manager_top; expects clk and rst_n in scope.
`ifndef TIMEOUT_STACK_MANAGER_TOP_DEFINES_SVH
`define TIMEOUT_STACK_MANAGER_TOP_DEFINES_SVH

// Consequent checked in the same cycle.
`define TSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tsm_pkg.sv
// Shared types and constants for the timeout stack manager.
// No dependencies.
package tsm_pkg;

    localparam int TSM_MAX_ENTRIES = 8;
    localparam int DEPTH_W         = 4;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_CANCEL  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [31:0] duration_ms;
        logic [7:0]  target_id;
    } cmd_t;

    typedef struct packed {
        logic [7:0]         new_id;
        logic               expired;
        logic [7:0]         expired_id;
        logic               showing;
        logic [31:0]        elapsed_ms;
        logic [31:0]        shown_duration_ms;
        logic [DEPTH_W-1:0] depth;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] start;
        logic [31:0] duration;
    } entry_t;

endpackage

// File: sv/tsm_stream_if.sv
// Valid/ready stream channel carrying one beat of a given payload type.
// Payload types come from tsm_pkg.
interface tsm_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/timeout_stack_manager_top.sv
// Timeout stack manager top: entry stack in tsm_ram, control FSM, result register.
// Depends on tsm_pkg, tsm_stream_if, tsm_ram and the defines header.
// Create goes straight to the result; tick reads the top entry first; cancel/restart
// run the serial id search and the shift, one RAM read and write per cycle.
// One beat at a time; a new beat is accepted while a result waits.
// Reset: stack empty, next id 1; RAM contents are not cleared.
`include "timeout_stack_manager_top_defines.svh"

module timeout_stack_manager_top
    import tsm_pkg::*;
#(
    parameter int MAX_ENTRIES = TSM_MAX_ENTRIES
) (
    input  logic          clk,
    input  logic          rst_n,
    tsm_stream_if.sink    cmd,
    tsm_stream_if.source  rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRCH  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_TICK  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       nid_reg, nid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       op_reg, op_next;
    logic [31:0]      now_reg, now_next;
    logic [7:0]       tid_reg, tid_next;
    rsp_t             res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_data_reg, out_data_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           rd;

    logic             cmd_fire;
    logic             more;
    logic [31:0]      elapsed;

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    assign more    = (CNT_W'(idx_reg) + CNT_W'(1)) < count_reg;
    assign elapsed = now_reg - rd.start;

    tsm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        nid_next       = nid_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        tid_next       = tid_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = rd;
        ram_raddr      = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next  = cmd.payload.op;
                    now_next = cmd.payload.now_ms;
                    tid_next = cmd.payload.target_id;
                    res_next = '0;
                    case (cmd.payload.op)
                        OP_CREATE:
                        begin
                            if (count_reg < CNT_MAX)
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = IDX_W'(count_reg);
                                ram_wdata.id    = nid_reg;
                                ram_wdata.start = cmd.payload.now_ms;
                                ram_wdata.duration = cmd.payload.duration_ms;
                                res_next.new_id = nid_reg;
                                nid_next   = (nid_reg == 8'hFF) ? 8'h01 : nid_reg + 8'd1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = ST_DONE;
                        end
                        OP_CANCEL, OP_RESTART:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = ST_SRCH;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                ram_raddr  = IDX_W'(count_reg - CNT_W'(1));
                                state_next = ST_TICK;
                            end
                        end
                    endcase
                end
            end
            ST_SRCH:
            begin
                if (rd.id == tid_reg)
                begin
                    if (op_reg == OP_RESTART)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata.start = now_reg;
                        state_next      = ST_DONE;
                    end
                    else if (more)
                    begin
                        ram_raddr  = idx_reg + IDX_W'(1);
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_DONE;
                    end
                end
                else if (more)
                begin
                    ram_raddr = idx_reg + IDX_W'(1);
                    idx_next  = idx_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg - IDX_W'(1);
                if (more)
                begin
                    ram_raddr = idx_reg + IDX_W'(1);
                    idx_next  = idx_reg + IDX_W'(1);
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end
            ST_TICK:
            begin
                if (elapsed >= rd.duration)
                begin
                    res_next.expired    = 1'b1;
                    res_next.expired_id = rd.id;
                    count_next          = count_reg - CNT_W'(1);
                end
                else
                begin
                    res_next.showing           = 1'b1;
                    res_next.elapsed_ms        = elapsed;
                    res_next.shown_duration_ms = rd.duration;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_next == ST_DONE && state_reg != ST_DONE)
        begin
            res_next.depth = DEPTH_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            nid_reg       <= 8'h01;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            nid_reg       <= nid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        op_reg       <= op_next;
        now_reg      <= now_next;
        tid_reg      <= tid_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    `TSM_ASSERT_NEXT(a_create_push, cmd_fire && cmd.payload.op == OP_CREATE && count_reg < CNT_MAX, count_reg == $past(count_reg) + CNT_W'(1), "create on non-full stack did not push")
    `TSM_ASSERT_NEXT(a_empty_tick, cmd_fire && cmd.payload.op == OP_TICK && count_reg == '0, state_reg == ST_DONE && !res_reg.expired && !res_reg.showing, "tick on empty stack reported an entry")
    `TSM_ASSERT_SAME(a_shift_range, state_reg == ST_SHIFT, idx_reg != '0 && CNT_W'(idx_reg) < count_reg, "shift index out of stack range")

endmodule

// File: sv/tsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsm_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
